// File: hdl/ufilt_pkg.sv
`default_nettype none

package ufilt_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned MAC_W    = 48;
  localparam int unsigned IP_W     = 32;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned VERD_W   = 4;
  localparam int unsigned HL_W     = 6;   // header length in bytes, IHL * 4
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 72; // 68 payload bits rounded up to bytes

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'd1;

  // Protocol constants
  localparam logic [CNT_W-1:0] ETH_HDR_LEN = 16'd14;
  localparam logic [CNT_W-1:0] IP_MIN_LEN  = 16'd20;
  localparam logic [CNT_W-1:0] UDP_HDR_LEN = 16'd8;
  localparam logic [CNT_W-1:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [15:0]      TYPE_IPV4   = 16'h0800;
  localparam logic [7:0]       PROTO_UDP   = 8'd17;
  localparam logic [15:0]      SUM_GOOD    = 16'hFFFF;
  localparam logic [IP_W-1:0]  IP_BCAST    = 32'hFFFF_FFFF;

  // Verdict codes
  localparam logic [VERD_W-1:0] V_ACCEPT    = 4'd0;
  localparam logic [VERD_W-1:0] V_RUNT      = 4'd1;
  localparam logic [VERD_W-1:0] V_MAC_MISS  = 4'd2;
  localparam logic [VERD_W-1:0] V_NOT_IPV4  = 4'd3;
  localparam logic [VERD_W-1:0] V_IP_SHORT  = 4'd4;
  localparam logic [VERD_W-1:0] V_IP_LEN    = 4'd5;
  localparam logic [VERD_W-1:0] V_CHECKSUM  = 4'd6;
  localparam logic [VERD_W-1:0] V_IP_MISS   = 4'd7;
  localparam logic [VERD_W-1:0] V_NOT_UDP   = 4'd8;
  localparam logic [VERD_W-1:0] V_UDP_SHORT = 4'd9;
  localparam logic [VERD_W-1:0] V_UDP_LEN   = 4'd10;

  // Frame state captured at the final byte, handed from parser to judge
  typedef struct packed {
    logic [CNT_W-1:0] frame_len;
    logic             mac_ok;
    logic [15:0]      frame_type;
    logic [3:0]       header_words;
    logic [15:0]      ip_total_length;
    logic [15:0]      header_sum;
    logic [7:0]       protocol_number;
    logic [IP_W-1:0]  ip_destination;
    logic [15:0]      udp_port;
    logic [15:0]      udp_length;
  } ufilt_snap_t;

endpackage

`default_nettype wire

// File: hdl/ufilt_parse.sv
`default_nettype none

module ufilt_parse
  import ufilt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              in_last,
  input  wire logic [MAC_W-1:0]  own_mac,
  input  wire logic              snap_free,
  output logic                   snap_load,
  output ufilt_snap_t            snap
);

  // Input register
  logic              in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              last_r;
  logic              proc;

  // Frame state
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic             mac_ok_r, mac_ok_nxt;
  logic             dst_group_r, dst_group_nxt;
  logic [15:0]      frame_type_r, frame_type_nxt;
  logic [3:0]       header_words_r, header_words_nxt;
  logic [15:0]      ip_total_length_r, ip_total_length_nxt;
  logic [15:0]      header_sum_r, header_sum_nxt;
  logic [7:0]       protocol_r, protocol_nxt;
  logic [IP_W-1:0]  ip_dest_r, ip_dest_nxt;
  logic [15:0]      udp_port_r, udp_port_nxt;
  logic [15:0]      udp_length_r, udp_length_nxt;
  logic [7:0]       hold_r, hold_nxt;

  // Updated values for the byte in the input register
  logic [CNT_W-1:0] p;
  logic [CNT_W-1:0] count_inc;
  logic [7:0]       own_byte;
  logic             grp_upd;
  logic             mac_upd;
  logic [15:0]      ft_upd;
  logic [3:0]       hw_upd;
  logic [HL_W-1:0]  hl;
  logic [CNT_W-1:0] o;
  logic [CNT_W-1:0] u;
  logic             in_ip;
  logic             in_sum;
  logic             past_hdr;
  logic [16:0]      sum_raw;
  logic [15:0]      sum_upd;
  logic [7:0]       hold_upd;
  logic [15:0]      iptl_upd;
  logic [7:0]       proto_upd;
  logic [IP_W-1:0]  ipd_upd;
  logic [15:0]      port_upd;
  logic [15:0]      ulen_upd;

  // Handshake: non-final bytes always drain, a final byte needs a free snapshot slot
  assign proc      = in_valid_r && (!last_r || snap_free);
  assign in_tready = !in_valid_r || proc;
  assign snap_load = proc && last_r;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (proc) begin
      in_valid_nxt = 1'b0;
    end
  end

  // Ethernet header: destination MAC match and ethertype
  assign p         = byte_count_r;
  assign count_inc = (p != COUNT_MAX) ? p + 16'd1 : COUNT_MAX;

  always_comb begin
    case (p[2:0])
      3'd0:    own_byte = own_mac[47:40];
      3'd1:    own_byte = own_mac[39:32];
      3'd2:    own_byte = own_mac[31:24];
      3'd3:    own_byte = own_mac[23:16];
      3'd4:    own_byte = own_mac[15:8];
      3'd5:    own_byte = own_mac[7:0];
      default: own_byte = 8'h00;
    endcase
  end

  assign grp_upd = (p == 16'd0) ? byte_r[0] : dst_group_r;
  assign mac_upd = (p < 16'd6) ? (mac_ok_r && (grp_upd || byte_r == own_byte)) : mac_ok_r;
  assign ft_upd  = (p == 16'd12 || p == 16'd13) ? {frame_type_r[7:0], byte_r}
                                                : frame_type_r;

  // IPv4 header: offset o from start of IP header
  assign in_ip  = (p >= ETH_HDR_LEN);
  assign o      = p - ETH_HDR_LEN;
  assign hw_upd = (in_ip && o == 16'd0) ? byte_r[3:0] : header_words_r;
  assign hl     = {hw_upd, 2'b00};
  assign in_sum = in_ip && (o[15:HL_W] == '0) && (o[HL_W-1:0] < hl);
  assign past_hdr = in_ip && (o >= {{(CNT_W-HL_W){1'b0}}, hl});
  assign u      = o - {{(CNT_W-HL_W){1'b0}}, hl};

  // Running ones'-complement sum, folded on every add
  assign sum_raw = {1'b0, header_sum_r} + {1'b0, hold_r, byte_r};

  always_comb begin
    sum_upd  = header_sum_r;
    hold_upd = hold_r;
    if (in_sum) begin
      if (!o[0]) begin
        hold_upd = byte_r;
      end else begin
        sum_upd = sum_raw[15:0] + {15'd0, sum_raw[16]};
      end
    end
  end

  assign iptl_upd  = (in_ip && (o == 16'd2 || o == 16'd3)) ? {ip_total_length_r[7:0], byte_r}
                                                           : ip_total_length_r;
  assign proto_upd = (in_ip && o == 16'd9) ? byte_r : protocol_r;
  assign ipd_upd   = (in_ip && o >= 16'd16 && o <= 16'd19) ? {ip_dest_r[23:0], byte_r}
                                                           : ip_dest_r;

  // UDP header fields, located after IHL*4 bytes
  assign port_upd = (past_hdr && (u == 16'd2 || u == 16'd3)) ? {udp_port_r[7:0], byte_r}
                                                             : udp_port_r;
  assign ulen_upd = (past_hdr && (u == 16'd4 || u == 16'd5)) ? {udp_length_r[7:0], byte_r}
                                                             : udp_length_r;

  // Next frame state: advance on each byte, clear after the final one
  always_comb begin
    byte_count_nxt      = byte_count_r;
    mac_ok_nxt          = mac_ok_r;
    dst_group_nxt       = dst_group_r;
    frame_type_nxt      = frame_type_r;
    header_words_nxt    = header_words_r;
    ip_total_length_nxt = ip_total_length_r;
    header_sum_nxt      = header_sum_r;
    protocol_nxt        = protocol_r;
    ip_dest_nxt         = ip_dest_r;
    udp_port_nxt        = udp_port_r;
    udp_length_nxt      = udp_length_r;
    hold_nxt            = hold_r;
    if (proc) begin
      if (last_r) begin
        byte_count_nxt      = '0;
        mac_ok_nxt          = 1'b1;
        dst_group_nxt       = 1'b0;
        frame_type_nxt      = '0;
        header_words_nxt    = '0;
        ip_total_length_nxt = '0;
        header_sum_nxt      = '0;
        protocol_nxt        = '0;
        ip_dest_nxt         = '0;
        udp_port_nxt        = '0;
        udp_length_nxt      = '0;
        hold_nxt            = '0;
      end else begin
        byte_count_nxt      = count_inc;
        mac_ok_nxt          = mac_upd;
        dst_group_nxt       = grp_upd;
        frame_type_nxt      = ft_upd;
        header_words_nxt    = hw_upd;
        ip_total_length_nxt = iptl_upd;
        header_sum_nxt      = sum_upd;
        protocol_nxt        = proto_upd;
        ip_dest_nxt         = ipd_upd;
        udp_port_nxt        = port_upd;
        udp_length_nxt      = ulen_upd;
        hold_nxt            = hold_upd;
      end
    end
  end

  // Snapshot of the updated state for the judge
  always_comb begin
    snap.frame_len       = count_inc;
    snap.mac_ok          = mac_upd;
    snap.frame_type      = ft_upd;
    snap.header_words    = hw_upd;
    snap.ip_total_length = iptl_upd;
    snap.header_sum      = sum_upd;
    snap.protocol_number = proto_upd;
    snap.ip_destination  = ipd_upd;
    snap.udp_port        = port_upd;
    snap.udp_length      = ulen_upd;
  end

  // Input byte register
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r        <= 1'b0;
      byte_count_r      <= '0;
      mac_ok_r          <= 1'b1;
      dst_group_r       <= 1'b0;
      frame_type_r      <= '0;
      header_words_r    <= '0;
      ip_total_length_r <= '0;
      header_sum_r      <= '0;
      protocol_r        <= '0;
      ip_dest_r         <= '0;
      udp_port_r        <= '0;
      udp_length_r      <= '0;
      hold_r            <= '0;
    end else begin
      in_valid_r        <= in_valid_nxt;
      byte_count_r      <= byte_count_nxt;
      mac_ok_r          <= mac_ok_nxt;
      dst_group_r       <= dst_group_nxt;
      frame_type_r      <= frame_type_nxt;
      header_words_r    <= header_words_nxt;
      ip_total_length_r <= ip_total_length_nxt;
      header_sum_r      <= header_sum_nxt;
      protocol_r        <= protocol_nxt;
      ip_dest_r         <= ip_dest_nxt;
      udp_port_r        <= udp_port_nxt;
      udp_length_r      <= udp_length_nxt;
      hold_r            <= hold_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ufilt_judge.sv
`default_nettype none

module ufilt_judge
  import ufilt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   snap_load,
  input  wire ufilt_snap_t            snap,
  input  wire logic [IP_W-1:0]        own_ip,
  output logic                        snap_free,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  logic                   snap_valid_r, snap_valid_nxt;
  ufilt_snap_t            snap_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_free;

  logic [CNT_W-1:0]  ip_len;
  logic [HL_W-1:0]   hl;
  logic [CNT_W-1:0]  rem;
  logic [VERD_W-1:0] verdict;
  logic [15:0]       payload;

  assign out_free  = !out_valid_r || out_tready;
  assign snap_free = !snap_valid_r || out_free;

  always_comb begin
    snap_valid_nxt = snap_valid_r;
    if (snap_load) begin
      snap_valid_nxt = 1'b1;
    end else if (out_free) begin
      snap_valid_nxt = 1'b0;
    end
  end

  assign out_valid_nxt = out_free ? snap_valid_r : out_valid_r;

  // Checks in priority order, first failure wins
  assign ip_len = snap_r.frame_len - ETH_HDR_LEN;
  assign hl     = {snap_r.header_words, 2'b00};
  assign rem    = ip_len - {{(CNT_W-HL_W){1'b0}}, hl};

  always_comb begin
    payload = 16'd0;
    if (snap_r.frame_len < ETH_HDR_LEN) begin
      verdict = V_RUNT;
    end else if (!snap_r.mac_ok) begin
      verdict = V_MAC_MISS;
    end else if (snap_r.frame_type != TYPE_IPV4) begin
      verdict = V_NOT_IPV4;
    end else if (ip_len < IP_MIN_LEN || ip_len < {{(CNT_W-HL_W){1'b0}}, hl}) begin
      verdict = V_IP_SHORT;
    end else if (ip_len != snap_r.ip_total_length) begin
      verdict = V_IP_LEN;
    end else if (snap_r.header_sum != SUM_GOOD) begin
      verdict = V_CHECKSUM;
    end else if (snap_r.ip_destination != IP_BCAST && snap_r.ip_destination != own_ip) begin
      verdict = V_IP_MISS;
    end else if (snap_r.protocol_number != PROTO_UDP) begin
      verdict = V_NOT_UDP;
    end else if (rem < UDP_HDR_LEN) begin
      verdict = V_UDP_SHORT;
    end else if (snap_r.udp_length != rem) begin
      verdict = V_UDP_LEN;
    end else begin
      verdict = V_ACCEPT;
      payload = rem - UDP_HDR_LEN;
    end
  end

  // Snapshot and result data registers
  always_ff @(posedge clk) begin
    if (snap_load) begin
      snap_r <= snap;
    end
    if (out_free) begin
      out_data_r <= {4'd0, payload, snap_r.udp_port, snap_r.ip_destination, verdict};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      snap_valid_r <= snap_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// File: hdl/udp_receive_frame_filter_unit.sv
// Verdict path: a final byte's verdict reaches out_tvalid through the input
//   register, the snapshot register and then the result register.
// Throughput: one byte per cycle; the input stalls only while a final byte
//   sits in the input register with both verdict slots full.
// Reset: synchronous, active low; clears frame state and both config registers.
`default_nettype none

module udp_receive_frame_filter_unit
  import ufilt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input frame bytes
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  wire logic                   in_tlast,   // last_byte
  // Verdicts
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [3:0] verdict, [35:4] dest_ip, [51:36] dest_port, [67:52] payload bytes,
  // [71:68] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // Configuration writes
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [MAC_W-1:0]       cfg_wdata
);

  logic [MAC_W-1:0] own_mac_r;
  logic [IP_W-1:0]  own_ip_r;
  logic             snap_free;
  logic             snap_load;
  ufilt_snap_t      snap;

  // Station address registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
      own_ip_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_OWN_MAC: own_mac_r <= cfg_wdata;
        CFG_OWN_IP:  own_ip_r  <= cfg_wdata[IP_W-1:0];
        default:     ;
      endcase
    end
  end

  ufilt_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata[BYTE_W-1:0]),
    .in_last   (in_tlast),
    .own_mac   (own_mac_r),
    .snap_free (snap_free),
    .snap_load (snap_load),
    .snap      (snap)
  );

  ufilt_judge u_judge (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_load  (snap_load),
    .snap       (snap),
    .own_ip     (own_ip_r),
    .snap_free  (snap_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// File: hdl/ufilt_checker.sv
`default_nettype none

module ufilt_checker
  import ufilt_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  // Stalled verdict holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("verdict changed while stalled");

  // No verdict pending right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid set after reset");

  // Only defined verdict codes are produced
  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= V_UDP_LEN)
    else $error("undefined verdict code");

  // Rejected frames report no payload length
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:0] != V_ACCEPT |-> out_tdata[67:52] == 16'd0)
    else $error("payload length on a rejected frame");

endmodule

bind udp_receive_frame_filter_unit ufilt_checker u_ufilt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
